### rtl/ipv4hv_pkg.sv
package ipv4hv_pkg;

    // Octet positions of the fixed IPv4 header fields
    localparam logic [15:0] POS_VER_IHL    = 16'd0;
    localparam logic [15:0] POS_TOS        = 16'd1;
    localparam logic [15:0] POS_LEN_HI     = 16'd2;
    localparam logic [15:0] POS_LEN_LO     = 16'd3;
    localparam logic [15:0] POS_ID_HI      = 16'd4;
    localparam logic [15:0] POS_ID_LO      = 16'd5;
    localparam logic [15:0] POS_FLAGS_HI   = 16'd6;
    localparam logic [15:0] POS_FLAGS_LO   = 16'd7;
    localparam logic [15:0] POS_TTL        = 16'd8;
    localparam logic [15:0] POS_PROTO      = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST  = 16'd12;
    localparam logic [15:0] POS_SRC_LAST   = 16'd15;
    localparam logic [15:0] POS_DST_FIRST  = 16'd16;
    localparam logic [15:0] POS_DST_LAST   = 16'd19;

    localparam logic [15:0] MIN_HDR_OCTETS = 16'd20;
    localparam logic [15:0] LEN_FIELD_END  = 16'd4;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
    localparam logic [3:0]  IPV4_VERSION   = 4'd4;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    // One octet request
    typedef struct packed {
        logic [7:0] octet;
        logic       last_octet;
    } t_in_req;

    // One verification result
    typedef struct packed {
        logic        header_ok;
        logic [5:0]  header_octets;
        logic [15:0] total_length;
        logic [15:0] payload_length;
        logic [7:0]  protocol_number;
        logic [7:0]  time_to_live;
        logic [7:0]  service_type;
        logic [15:0] identification;
        logic [15:0] flags_and_offset;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic        is_fragment;
    } t_result;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        begin
            s = {1'b0, a} + {1'b0, b};
            f = {1'b0, s[15:0]} + {16'd0, s[16]};
            ones_add = f[15:0];
        end
    endfunction

endpackage

### rtl/ipv4hv_in_stage.sv
module ipv4hv_in_stage
    import ipv4hv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_data,
    input  logic    i_out_free,
    output logic    o_fire,
    output t_in_req o_req
);

    logic    r_valid;
    logic    n_valid;
    t_in_req r_req;

    // A last octet needs room in the result register; others always move on
    assign o_fire     = r_valid && (!r_req.last_octet || i_out_free);
    assign o_in_ready = !r_valid || o_fire;
    assign o_req      = r_req;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, loaded on every accepted request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_data;
        end
    end

endmodule

### rtl/ipv4hv_parse.sv
module ipv4hv_parse
    import ipv4hv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_in_req i_req,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [15:0] r_count;
    logic [15:0] r_sum;
    logic [7:0]  r_pend;
    logic [7:0]  r_vi;
    logic [7:0]  r_tos;
    logic [15:0] r_len;
    logic [15:0] r_id;
    logic [15:0] r_flags;
    logic [7:0]  r_ttl;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;

    logic [15:0] n_count;
    logic [15:0] n_sum;
    logic [7:0]  n_pend;
    logic [7:0]  n_vi;
    logic [7:0]  n_tos;
    logic [15:0] n_len;
    logic [15:0] n_id;
    logic [15:0] n_flags;
    logic [7:0]  n_ttl;
    logic [7:0]  n_proto;
    logic [31:0] n_src;
    logic [31:0] n_dst;

    logic [5:0]  hdr_octets;
    logic        in_hdr;
    logic [15:0] total;
    logic        ok;

    // Field capture by octet position
    always_comb begin
        n_vi    = r_vi;
        n_tos   = r_tos;
        n_len   = r_len;
        n_id    = r_id;
        n_flags = r_flags;
        n_ttl   = r_ttl;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        case (r_count)
            POS_VER_IHL:  n_vi         = i_req.octet;
            POS_TOS:      n_tos        = i_req.octet;
            POS_LEN_HI:   n_len[15:8]  = i_req.octet;
            POS_LEN_LO:   n_len[7:0]   = i_req.octet;
            POS_ID_HI:    n_id[15:8]   = i_req.octet;
            POS_ID_LO:    n_id[7:0]    = i_req.octet;
            POS_FLAGS_HI: n_flags[15:8] = i_req.octet;
            POS_FLAGS_LO: n_flags[7:0] = i_req.octet;
            POS_TTL:      n_ttl        = i_req.octet;
            POS_PROTO:    n_proto      = i_req.octet;
            default: begin
                // big-endian: the first octet of an address lands in the top byte
                if (r_count inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
                    n_src[{~r_count[1:0], 3'b000} +: 8] = i_req.octet;
                end else if (r_count inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
                    n_dst[{~r_count[1:0], 3'b000} +: 8] = i_req.octet;
                end
            end
        endcase
    end

    // Header sum over IHL*4 octets; IHL comes from this octet on the first one
    assign hdr_octets = {n_vi[3:0], 2'b00};
    assign in_hdr     = r_count < {10'd0, hdr_octets};

    always_comb begin
        n_pend = r_pend;
        n_sum  = r_sum;
        if (in_hdr) begin
            if (!r_count[0]) begin
                n_pend = i_req.octet;
            end else begin
                n_sum = ones_add(r_sum, {r_pend, i_req.octet});
            end
        end
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
    end

    // Checks and result fields, from the state after this octet
    assign total = (n_count >= LEN_FIELD_END) ? n_len : 16'd0;
    assign ok    = (n_count >= MIN_HDR_OCTETS) && (n_vi[7:4] == IPV4_VERSION)
                && (n_vi[3:0] >= IHL_MIN) && ({10'd0, hdr_octets} <= n_count)
                && (total >= {10'd0, hdr_octets}) && (total <= n_count)
                && (n_sum == SUM_GOOD);

    assign o_res_valid = i_fire && i_req.last_octet;

    always_comb begin
        o_res.header_ok        = ok;
        o_res.header_octets    = hdr_octets;
        o_res.total_length     = total;
        o_res.payload_length   = ok ? (total - {10'd0, hdr_octets}) : 16'd0;
        o_res.protocol_number  = n_proto;
        o_res.time_to_live     = n_ttl;
        o_res.service_type     = n_tos;
        o_res.identification   = n_id;
        o_res.flags_and_offset = n_flags;
        o_res.source_address   = n_src;
        o_res.dest_address     = n_dst;
        o_res.is_fragment      = |n_flags[13:0];
    end

    // Datagram state; cleared by reset and after each last octet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= '0;
            r_vi    <= '0;
            r_tos   <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_flags <= '0;
            r_ttl   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_vi    <= n_vi;
            r_tos   <= n_tos;
            r_len   <= n_len;
            r_id    <= n_id;
            r_flags <= n_flags;
            r_ttl   <= n_ttl;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end
    end

endmodule

### rtl/ipv4hv_out_stage.sv
module ipv4hv_out_stage
    import ipv4hv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_res;

    // Result register occupancy
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/ipv4_header_verifier.sv
// IPv4 header verifier: takes a datagram one octet per request, the final
// readable octet flagged by last_octet, and gives one result request per
// datagram with the pass/fail verdict (version 4, IHL 5..15, at least 20
// octets, header and Total Length within the octets read, Total Length
// covering the header, ones' complement header sum of 0xFFFF) and the decoded
// fixed header fields. One octet is accepted every clock. An octet is held in
// the input register, then the parse stage updates the running count,
// header sum and field captures; on the last octet the result is written to
// the output register, from which it is offered to the receiver. Input stalls
// only when a last octet meets a result still waiting in the output register.
module ipv4_header_verifier
    import ipv4hv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic    out_free;
    logic    fire;
    t_in_req req;
    logic    res_valid;
    t_result res;

    ipv4hv_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_req      (req)
    );

    ipv4hv_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ipv4hv_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### sim/testbench.sv
module testbench;
    import ipv4hv_pkg::*;

    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 7;
    localparam int RANDOM_OCTETS     = 1024;
    localparam int MIN_RANDOM_DGRAMS = 32;
    localparam int DRAIN_CYCLES      = 16;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int NUM_ROWS          = 18;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_NOISE} t_fill;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // One datagram to send; ok/hoct/tlen only matter when typed is set
    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tl;
        logic [16:0] n;
        logic        bad_sum;
        t_fill       fill;
        logic        typed;
        logic        ok;
        logic [5:0]  hoct;
        logic [15:0] tlen;
    } t_dg_row;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_in_req in_req = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_result out_result;

    t_idle       idle_mode = IDLE_NONE;
    t_dg_row     directed_rows [0:NUM_ROWS-1];
    t_result     verdicts_due [$];
    t_result     oldest_verdict;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned dgram_count = 0;
    int unsigned octet_count = 0;
    int unsigned good_count = 0;
    int unsigned frag_count = 0;

    // Verdict fields typed into the directed table for the datagram in flight
    logic        typed_pending = 1'b0;
    logic        typed_ok;
    logic [5:0]  typed_hoct;
    logic [15:0] typed_tlen;

    // Shadow of the parser state
    logic [15:0] p_count;
    logic [15:0] p_sum;
    logic [7:0]  p_high;
    logic [7:0]  p_vihl;
    logic [7:0]  p_tos;
    logic [15:0] p_len;
    logic [15:0] p_ident;
    logic [15:0] p_flags;
    logic [7:0]  p_ttl;
    logic [7:0]  p_proto;
    logic [31:0] p_src;
    logic [31:0] p_dst;

    ipv4_header_verifier i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_result)
    );

    always #CLK_HALF clk = ~clk;

    // 16-bit ones' complement add, carry folded back in
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic int unsigned gap_pct(input t_idle mode, input logic sender);
        case (mode)
            IDLE_BOTH: return 30;
            IDLE_SEND: return sender ? 46 : 0;
            IDLE_RECV: return sender ? 0 : 46;
            default:   return 0;
        endcase
    endfunction

    task automatic clear_tracker();
        p_count = '0;
        p_sum   = '0;
        p_high  = '0;
        p_vihl  = '0;
        p_tos   = '0;
        p_len   = '0;
        p_ident = '0;
        p_flags = '0;
        p_ttl   = '0;
        p_proto = '0;
        p_src   = '0;
        p_dst   = '0;
    endtask

    // Advance the shadow parser by one accepted octet; queue the verdict on the last one
    task automatic track_octet(input t_in_req r);
        logic [15:0] idx;
        logic [15:0] hdr;
        logic [15:0] n;
        logic [15:0] total;
        logic        ok;
        t_result     res;
        idx = p_count;
        octet_count++;

        // field capture by octet position
        case (idx)
            POS_VER_IHL:  p_vihl = r.octet;
            POS_TOS:      p_tos = r.octet;
            POS_LEN_HI:   p_len[15:8] = r.octet;
            POS_LEN_LO:   p_len[7:0] = r.octet;
            POS_ID_HI:    p_ident[15:8] = r.octet;
            POS_ID_LO:    p_ident[7:0] = r.octet;
            POS_FLAGS_HI: p_flags[15:8] = r.octet;
            POS_FLAGS_LO: p_flags[7:0] = r.octet;
            POS_TTL:      p_ttl = r.octet;
            POS_PROTO:    p_proto = r.octet;
            default: begin
                if (idx >= POS_SRC_FIRST && idx <= POS_SRC_LAST)
                    p_src[(POS_SRC_LAST - idx) * 8 +: 8] = r.octet;
                else if (idx >= POS_DST_FIRST && idx <= POS_DST_LAST)
                    p_dst[(POS_DST_LAST - idx) * 8 +: 8] = r.octet;
            end
        endcase

        // header sum over IHL*4 octets, high octet first
        hdr = {10'd0, p_vihl[3:0], 2'b00};
        if (idx < hdr) begin
            if (!idx[0])
                p_high = r.octet;
            else
                p_sum = fold_add(p_sum, {p_high, r.octet});
        end
        if (p_count != COUNT_MAX)
            p_count = p_count + 16'd1;

        if (r.last_octet) begin
            n = p_count;
            total = (n >= LEN_FIELD_END) ? p_len : '0;
            ok = n >= MIN_HDR_OCTETS && p_vihl[7:4] == IPV4_VERSION &&
                 p_vihl[3:0] >= IHL_MIN && hdr <= n && total >= hdr &&
                 total <= n && p_sum == SUM_GOOD;
            res.header_ok        = ok;
            res.header_octets    = hdr[5:0];
            res.total_length     = total;
            res.payload_length   = ok ? total - hdr : '0;
            res.protocol_number  = p_proto;
            res.time_to_live     = p_ttl;
            res.service_type     = p_tos;
            res.identification   = p_ident;
            res.flags_and_offset = p_flags;
            res.source_address   = p_src;
            res.dest_address     = p_dst;
            res.is_fragment      = |p_flags[13:0];
            if (typed_pending) begin
                res.header_ok      = typed_ok;
                res.header_octets  = typed_hoct;
                res.total_length   = typed_tlen;
                res.payload_length = typed_ok ? typed_tlen - {10'd0, typed_hoct} : '0;
                typed_pending      = 1'b0;
            end
            verdicts_due.push_back(res);
            dgram_count++;
            if (res.header_ok)
                good_count++;
            if (res.is_fragment)
                frag_count++;
            clear_tracker();
        end
    endtask

    // Offer one octet request from a falling edge; returns at the falling edge after acceptance
    task automatic send_octet(input t_in_req r);
        while ($urandom_range(99) < gap_pct(idle_mode, 1'b1)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        track_octet(r);
        @(negedge clk);
    endtask

    // Build the header image, fix the checksum (not for noise fill) and stream the datagram out
    task automatic send_datagram(input t_dg_row row);
        logic [7:0]  img [0:59];
        logic [15:0] csum;
        int unsigned hdr;
        int unsigned i;
        t_in_req     r;
        hdr = row.ihl * 4;
        for (i = 0; i < 60; i++) begin
            case (row.fill)
                FILL_ZERO: img[i] = 8'h00;
                FILL_ONES: img[i] = 8'hFF;
                default:   img[i] = 8'($urandom_range(255));
            endcase
        end
        if (row.fill != FILL_NOISE) begin
            img[0]  = {row.ver, row.ihl};
            img[2]  = row.tl[15:8];
            img[3]  = row.tl[7:0];
            img[10] = 8'h00;
            img[11] = 8'h00;
            csum = '0;
            for (i = 0; i + 1 < hdr; i += 2)
                csum = fold_add(csum, {img[i], img[i+1]});
            csum = ~csum;
            // one flipped bit always breaks the sum
            if (row.bad_sum)
                csum = csum ^ (16'd1 << $urandom_range(15));
            if (hdr >= 12) begin
                img[10] = csum[15:8];
                img[11] = csum[7:0];
            end
        end
        typed_pending = row.typed;
        typed_ok      = row.ok;
        typed_hoct    = row.hoct;
        typed_tlen    = row.tlen;
        for (i = 0; i < row.n; i++) begin
            if (i < 60)
                r.octet = img[i];
            else if (row.fill == FILL_ZERO)
                r.octet = 8'h00;
            else if (row.fill == FILL_ONES)
                r.octet = 8'hFF;
            else
                r.octet = 8'($urandom_range(255));
            r.last_octet = (i == row.n - 1);
            send_octet(r);
        end
    endtask

    // Mostly well-formed datagrams with random content, some broken, some noise
    function automatic t_dg_row make_random_row();
        t_dg_row     row;
        int unsigned hdr;
        int unsigned roll;
        row = '0;
        row.fill = FILL_RANDOM;
        row.ver = IPV4_VERSION;
        row.ihl = $urandom_range(1) ? IHL_MIN : 4'($urandom_range(15, 5));
        hdr = row.ihl * 4;
        row.tl = 16'(hdr + $urandom_range(12));
        row.n = 17'(row.tl + (($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0));
        roll = $urandom_range(99);
        if (roll >= 85) begin
            row.fill = FILL_NOISE;
            row.n = 17'($urandom_range(40, 1));
        end else if (roll >= 65) begin
            case ($urandom_range(5))
                0: row.bad_sum = 1'b1;
                1: row.ver = IPV4_VERSION ^ 4'($urandom_range(15, 1));
                2: row.ihl = 4'($urandom_range(4));
                3: row.tl = 16'($urandom_range(hdr - 1));
                4: row.tl = 16'(row.n + $urandom_range(30, 1));
                default: row.n = 17'($urandom_range(row.n - 1, 1));
            endcase
        end
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= gap_pct(idle_mode, 1'b0));

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("Result request with no datagram outstanding");
                mismatches++;
            end else begin
                oldest_verdict = verdicts_due.pop_front();
                check_field("header_ok", oldest_verdict.header_ok, out_result.header_ok);
                check_field("header_octets", oldest_verdict.header_octets,
                            out_result.header_octets);
                check_field("total_length", oldest_verdict.total_length,
                            out_result.total_length);
                check_field("payload_length", oldest_verdict.payload_length,
                            out_result.payload_length);
                check_field("protocol_number", oldest_verdict.protocol_number,
                            out_result.protocol_number);
                check_field("time_to_live", oldest_verdict.time_to_live,
                            out_result.time_to_live);
                check_field("service_type", oldest_verdict.service_type,
                            out_result.service_type);
                check_field("identification", oldest_verdict.identification,
                            out_result.identification);
                check_field("flags_and_offset", oldest_verdict.flags_and_offset,
                            out_result.flags_and_offset);
                check_field("source_address", oldest_verdict.source_address,
                            out_result.source_address);
                check_field("dest_address", oldest_verdict.dest_address,
                            out_result.dest_address);
                check_field("is_fragment", oldest_verdict.is_fragment,
                            out_result.is_fragment);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdicts_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_dg_row     row;
        int unsigned random_octets;
        int unsigned random_dgrams;
        int unsigned k;
        random_octets = 0;
        random_dgrams = 0;
        clear_tracker();

        // ver ihl tl n bad fill typed | ok hoct tlen
        directed_rows = '{
            // single octet right after reset
            '{4'd4, 4'd5, 16'd20, 17'd1, 1'b0, FILL_ZERO, 1'b1, 1'b0, 6'd20, 16'd0},
            // length field cut after its high octet
            '{4'd4, 4'd5, 16'd20, 17'd3, 1'b0, FILL_ZERO, 1'b1, 1'b0, 6'd20, 16'd0},
            '{4'd4, 4'd5, 16'd20, 17'd4, 1'b0, FILL_ZERO, 1'b1, 1'b0, 6'd20, 16'd20},
            // minimal good headers, zero and ones content
            '{4'd4, 4'd5, 16'd20, 17'd20, 1'b0, FILL_ZERO, 1'b1, 1'b1, 6'd20, 16'd20},
            '{4'd4, 4'd5, 16'd20, 17'd20, 1'b0, FILL_ONES, 1'b1, 1'b1, 6'd20, 16'd20},
            // largest header with options
            '{4'd4, 4'd15, 16'd65, 17'd65, 1'b0, FILL_RANDOM, 1'b1, 1'b1, 6'd60, 16'd65},
            // corrupt checksum
            '{4'd4, 4'd5, 16'd40, 17'd40, 1'b1, FILL_RANDOM, 1'b1, 1'b0, 6'd20, 16'd40},
            // wrong version
            '{4'd6, 4'd5, 16'd20, 17'd20, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd20, 16'd20},
            '{4'd0, 4'd0, 16'd20, 17'd20, 1'b0, FILL_ZERO, 1'b1, 1'b0, 6'd0, 16'd20},
            '{4'd15, 4'd15, 16'hFFFF, 17'd60, 1'b0, FILL_ONES, 1'b1, 1'b0, 6'd60, 16'hFFFF},
            // IHL below five, sum good only where the header reaches the checksum
            '{4'd4, 4'd4, 16'd16, 17'd20, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd16, 16'd16},
            '{4'd4, 4'd1, 16'd20, 17'd20, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd4, 16'd20},
            // Total Length past the octets read
            '{4'd4, 4'd5, 16'd40, 17'd30, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd20, 16'd40},
            // Total Length short of the header
            '{4'd4, 4'd6, 16'd20, 17'd24, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd24, 16'd20},
            // trailing pad after the datagram
            '{4'd4, 4'd5, 16'd28, 17'd40, 1'b0, FILL_RANDOM, 1'b1, 1'b1, 6'd20, 16'd28},
            // short datagram
            '{4'd4, 4'd5, 16'd19, 17'd19, 1'b0, FILL_RANDOM, 1'b1, 1'b0, 6'd20, 16'd19},
            // random fields, fragment bits and options
            '{4'd4, 4'd7, 16'd100, 17'd100, 1'b0, FILL_RANDOM, 1'b0, 1'b0, 6'd0, 16'd0},
            '{4'd4, 4'd5, 16'd20, 17'd20, 1'b0, FILL_RANDOM, 1'b0, 1'b0, 6'd0, 16'd0}
        };

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed datagrams, no idling
        for (k = 0; k < NUM_ROWS; k++)
            send_datagram(directed_rows[k]);

        // random datagrams, idle pattern changes every eight
        while (random_octets < RANDOM_OCTETS || random_dgrams < MIN_RANDOM_DGRAMS) begin
            idle_mode = t_idle'((random_dgrams / 8) % 4);
            row = make_random_row();
            send_datagram(row);
            random_octets += row.n;
            random_dgrams++;
        end
        in_valid <= 1'b0;

        // drain
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d datagrams over %0d octets: %0d good headers, %0d rejected",
                 dgram_count, octet_count, good_count, dgram_count - good_count);
        $display("%0d fragments seen; random part ran %0d datagrams under four idle patterns",
                 frag_count, random_dgrams);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
